// ----- hw/rtl/led_pattern_generator_macros.svh -----
// Assertion macros shared by the LED pattern generator RTL.
`ifndef LED_PATTERN_GENERATOR_MACROS_SVH
`define LED_PATTERN_GENERATOR_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define LPG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpg assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define LPG_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpg assertion failed");

`endif

// ----- hw/rtl/lpg_pkg.sv -----
// Package with types and constants of the LED pattern generator.
`timescale 1ns / 1ps
`default_nettype none

package lpg_pkg;

   localparam int LEVEL_BITS       = 8;
   localparam int PULSE_REFRESH_MS = 20;
   localparam int TIME_W           = 32;
   localparam int INTERVAL_W       = 16;
   localparam int DVS_W            = INTERVAL_W + 1;
   localparam int CNT_W            = $clog2(TIME_W);
   localparam int SCALED_W         = INTERVAL_W + LEVEL_BITS;
   localparam int ADDR_W           = 5;
   localparam int DATA_W           = 32;

   localparam logic [LEVEL_BITS-1:0] RAMP_TOP = '1;

   localparam logic [2:0] REG_FAST_INTERVAL = 3'd0;
   localparam logic [2:0] REG_SLOW_INTERVAL = 3'd1;
   localparam logic [2:0] REG_WARN_INTERVAL = 3'd2;
   localparam logic [2:0] REG_CUSTOM_ON     = 3'd3;
   localparam logic [2:0] REG_CUSTOM_OFF    = 3'd4;
   localparam logic [2:0] REG_FULL_LEVEL    = 3'd5;

   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_START = 2'd1,
      MODE_ON    = 2'd2,
      MODE_LEVEL = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      PAT_OFF    = 3'd0,
      PAT_ON     = 3'd1,
      PAT_FAST   = 3'd2,
      PAT_SLOW   = 3'd3,
      PAT_WARN   = 3'd4,
      PAT_PULSE  = 3'd5,
      PAT_CUSTOM = 3'd6,
      PAT_NONE   = 3'd7
   } pattern_type;

   typedef struct packed {
      logic [INTERVAL_W-1:0] fast_interval;
      logic [INTERVAL_W-1:0] slow_interval;
      logic [INTERVAL_W-1:0] warn_interval;
      logic [INTERVAL_W-1:0] custom_on;
      logic [INTERVAL_W-1:0] custom_off;
      logic [LEVEL_BITS-1:0] full_level;
   } cfg_type;

   typedef struct packed {
      logic              start;
      logic [TIME_W-1:0] dividend;
      logic [DVS_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [TIME_W-1:0] quotient;
      logic [DVS_W-1:0]  remainder;
   } div_rsp_type;

endpackage

`default_nettype wire

// ----- hw/rtl/lpg_csr.sv -----
// Configuration register file of the LED pattern generator.
`timescale 1ns / 1ps
`default_nettype none

module lpg_csr (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [lpg_pkg::ADDR_W-1:0] paddr,
   input  wire logic [lpg_pkg::DATA_W-1:0] pwdata,
   output logic      [lpg_pkg::DATA_W-1:0] prdata,
   output logic                            pready,
   output lpg_pkg::cfg_type                cfg
);
   import lpg_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_FAST_INTERVAL: cfg_in.fast_interval = pwdata[INTERVAL_W-1:0];
            REG_SLOW_INTERVAL: cfg_in.slow_interval = pwdata[INTERVAL_W-1:0];
            REG_WARN_INTERVAL: cfg_in.warn_interval = pwdata[INTERVAL_W-1:0];
            REG_CUSTOM_ON:     cfg_in.custom_on     = pwdata[INTERVAL_W-1:0];
            REG_CUSTOM_OFF:    cfg_in.custom_off    = pwdata[INTERVAL_W-1:0];
            REG_FULL_LEVEL:    cfg_in.full_level    = pwdata[LEVEL_BITS-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fast_interval <= INTERVAL_W'(100);
         cfg_ff.slow_interval <= INTERVAL_W'(1000);
         cfg_ff.warn_interval <= INTERVAL_W'(250);
         cfg_ff.custom_on     <= INTERVAL_W'(500);
         cfg_ff.custom_off    <= INTERVAL_W'(500);
         cfg_ff.full_level    <= LEVEL_BITS'(255);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_FAST_INTERVAL: prdata = DATA_W'(cfg_ff.fast_interval);
         REG_SLOW_INTERVAL: prdata = DATA_W'(cfg_ff.slow_interval);
         REG_WARN_INTERVAL: prdata = DATA_W'(cfg_ff.warn_interval);
         REG_CUSTOM_ON:     prdata = DATA_W'(cfg_ff.custom_on);
         REG_CUSTOM_OFF:    prdata = DATA_W'(cfg_ff.custom_off);
         REG_FULL_LEVEL:    prdata = DATA_W'(cfg_ff.full_level);
         default:           prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/lpg_divider.sv -----
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "led_pattern_generator_macros.svh"

module lpg_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lpg_pkg::div_req_type div_req,
   output lpg_pkg::div_rsp_type      div_rsp
);
   import lpg_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [TIME_W-1:0] quot_ff, quot_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVS_W:0]    trial;
   logic [DVS_W:0]    diff;
   logic              take;
   logic              last_step;

   assign trial     = {rem_ff, quot_ff[TIME_W-1]};
   assign diff      = trial - {1'b0, dvs_ff};
   assign take      = trial >= {1'b0, dvs_ff};
   assign last_step = (count_ff == CNT_W'(TIME_W - 1));

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      dvs_in   = dvs_ff;
      if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quot_in  = div_req.dividend;
         dvs_in   = div_req.divisor;
      end else if (busy_ff) begin
         rem_in   = take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         quot_in  = {quot_ff[TIME_W-2:0], take};
         count_in = count_ff + 1'b1;
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
      dvs_ff   <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quot_ff;
   assign div_rsp.remainder = rem_ff;

   `LPG_ASSERT_IMP(a_start_when_idle, clock, reset, div_req.start, !busy_ff)
   `LPG_ASSERT_IMP(a_done_not_busy, clock, reset, done_ff, !busy_ff)
   `LPG_ASSERT_NXT(a_last_step_done, clock, reset, busy_ff && !div_req.start && last_step, done_ff)

endmodule

`default_nettype wire

// ----- hw/rtl/led_pattern_generator.sv -----
// Top level and sequencer of the LED pattern generator.
//
// Each item on the req channel is a 1 ms tick or a command (start a pattern,
// turn on at a level, set the level). Every accepted item yields exactly one
// item on the rsp channel carrying the duty, the stored level, the lit flag,
// the active pattern and whether a pattern is running. Interval and level
// registers sit behind the APB port; the user must write them only while the
// block is idle; the block itself does not enforce this. A command passes
// S_DONE, a tick of the off, on, none and blink patterns S_TICK and S_DONE,
// and a pulse tick also S_MOD, S_SCALE and S_DIV: the ramp position needs a
// modulo and a scaling division, both run on one 32-step shared divider. One
// item is worked on at a time: req_stall is high from acceptance until the
// result is handed to the output register. The output register holds a
// result while rsp_stall is high, and the next item may already be accepted
// meanwhile. Synchronous reset clears the time base, the pattern state and
// the output valid, and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "led_pattern_generator_macros.svh"

module led_pattern_generator (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [1:0]                 req_mode,
   input  wire logic [2:0]                 req_pattern_sel,
   input  wire logic [31:0]                req_run_ms,
   input  wire logic [7:0]                 req_level_in,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [7:0]                      rsp_duty,
   output logic [7:0]                      rsp_level,
   output logic                            rsp_lit,
   output logic [2:0]                      rsp_active_pattern,
   output logic                            rsp_pattern_running,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [lpg_pkg::ADDR_W-1:0] paddr,
   input  wire logic [lpg_pkg::DATA_W-1:0] pwdata,
   output logic      [lpg_pkg::DATA_W-1:0] prdata,
   output logic                            pready
);
   import lpg_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_TICK  = 6'b000010,
      S_MOD   = 6'b000100,
      S_SCALE = 6'b001000,
      S_DIV   = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   cfg_type     cfg;
   div_req_type div_req;
   div_rsp_type div_rsp;

   state_type             state_ff, state_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [TIME_W-1:0]     start_ff, start_in;
   logic [TIME_W-1:0]     step_ff, step_in;
   logic [TIME_W-1:0]     run_ff, run_in;
   pattern_type           pat_ff, pat_in;
   logic                  phase_ff, phase_in;
   logic [LEVEL_BITS-1:0] lvl_ff, lvl_in;
   logic                  on_ff, on_in;
   logic [LEVEL_BITS-1:0] duty_ff, duty_in;
   logic [INTERVAL_W-1:0] ep_ff, ep_in;
   logic                  inv_ff, inv_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_BITS-1:0] rsp_duty_ff, rsp_duty_in;
   logic [LEVEL_BITS-1:0] rsp_level_ff, rsp_level_in;
   logic                  rsp_lit_ff, rsp_lit_in;
   logic [2:0]            rsp_pat_ff, rsp_pat_in;
   logic                  rsp_run_ff, rsp_run_in;

   logic                  req_take;
   logic                  out_free;
   logic [TIME_W-1:0]     elapsed;
   logic [TIME_W-1:0]     step_elapsed;
   logic [INTERVAL_W-1:0] interval;
   logic [INTERVAL_W-1:0] half;
   logic [DVS_W-1:0]      rem_pos;
   logic [SCALED_W-1:0]   scaled;
   logic [LEVEL_BITS-1:0] quot_lvl;
   logic [LEVEL_BITS-1:0] ramp_lvl;

   lpg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lpg_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_stall    = (state_ff != S_IDLE);
   assign req_take     = req_valid && !req_stall;
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign elapsed      = now_ff - start_ff;
   assign step_elapsed = now_ff - step_ff;
   assign half         = (cfg.slow_interval == '0) ? INTERVAL_W'(1) : cfg.slow_interval;
   assign rem_pos      = div_rsp.remainder;
   assign scaled       = {ep_ff, {LEVEL_BITS{1'b0}}} - {{LEVEL_BITS{1'b0}}, ep_ff};
   assign quot_lvl     = div_rsp.quotient[LEVEL_BITS-1:0];
   assign ramp_lvl     = inv_ff ? (RAMP_TOP - quot_lvl) : quot_lvl;

   always_comb begin
      case (pat_ff)
         PAT_FAST:   interval = cfg.fast_interval;
         PAT_SLOW:   interval = cfg.slow_interval;
         PAT_WARN:   interval = cfg.warn_interval;
         PAT_CUSTOM: interval = phase_ff ? cfg.custom_on : cfg.custom_off;
         default:    interval = cfg.slow_interval;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      now_in   = now_ff;
      start_in = start_ff;
      step_in  = step_ff;
      run_in   = run_ff;
      pat_in   = pat_ff;
      phase_in = phase_ff;
      lvl_in   = lvl_ff;
      on_in    = on_ff;
      duty_in  = duty_ff;
      ep_in    = ep_ff;
      inv_in   = inv_ff;

      div_req.start    = 1'b0;
      div_req.dividend = elapsed;
      div_req.divisor  = {half, 1'b0};

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_duty_in  = rsp_duty_ff;
      rsp_level_in = rsp_level_ff;
      rsp_lit_in   = rsp_lit_ff;
      rsp_pat_in   = rsp_pat_ff;
      rsp_run_in   = rsp_run_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_DONE;
               case (mode_type'(req_mode))
                  MODE_TICK: begin
                     now_in   = now_ff + 1'b1;
                     state_in = S_TICK;
                  end
                  MODE_START: begin
                     pat_in   = pattern_type'(req_pattern_sel);
                     start_in = now_ff;
                     step_in  = now_ff;
                     run_in   = req_run_ms;
                     phase_in = 1'b0;
                     if (pattern_type'(req_pattern_sel) == PAT_OFF) begin
                        lvl_in  = '0;
                        on_in   = 1'b0;
                        duty_in = '0;
                     end else if (pattern_type'(req_pattern_sel) == PAT_ON) begin
                        lvl_in  = cfg.full_level;
                        on_in   = 1'b1;
                        duty_in = cfg.full_level;
                     end
                  end
                  MODE_ON: begin
                     pat_in  = PAT_ON;
                     lvl_in  = req_level_in;
                     on_in   = 1'b1;
                     duty_in = req_level_in;
                  end
                  MODE_LEVEL: begin
                     lvl_in = req_level_in;
                     if (on_ff) begin
                        duty_in = req_level_in;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_TICK: begin
            state_in = S_DONE;
            if ((run_ff != '0) && (elapsed >= run_ff)) begin
               run_in  = '0;
               pat_in  = PAT_OFF;
               lvl_in  = '0;
               on_in   = 1'b0;
               duty_in = '0;
            end else begin
               case (pat_ff) inside
                  PAT_FAST, PAT_SLOW, PAT_WARN, PAT_CUSTOM: begin
                     if (step_elapsed >= TIME_W'(interval)) begin
                        phase_in = !phase_ff;
                        step_in  = now_ff;
                        lvl_in   = phase_ff ? '0 : cfg.full_level;
                        on_in    = !phase_ff;
                        duty_in  = phase_ff ? '0 : cfg.full_level;
                     end
                  end
                  PAT_PULSE: begin
                     div_req.start = 1'b1;
                     state_in      = S_MOD;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_MOD: begin
            if (div_rsp.done) begin
               state_in = S_SCALE;
               if (rem_pos < {1'b0, half}) begin
                  ep_in  = rem_pos[INTERVAL_W-1:0];
                  inv_in = 1'b0;
               end else begin
                  ep_in  = INTERVAL_W'(rem_pos - {1'b0, half});
                  inv_in = 1'b1;
               end
            end
         end
         S_SCALE: begin
            div_req.start    = 1'b1;
            div_req.dividend = TIME_W'(scaled);
            div_req.divisor  = {1'b0, half};
            state_in         = S_DIV;
         end
         S_DIV: begin
            if (div_rsp.done) begin
               state_in = S_DONE;
               lvl_in   = ramp_lvl;
               on_in    = (ramp_lvl != '0);
               if (step_elapsed >= TIME_W'(PULSE_REFRESH_MS)) begin
                  step_in = now_ff;
                  duty_in = ramp_lvl;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_duty_in  = duty_ff;
               rsp_level_in = lvl_ff;
               rsp_lit_in   = on_ff && (lvl_ff != '0);
               rsp_pat_in   = pat_ff;
               rsp_run_in   = (pat_ff != PAT_OFF);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         now_ff       <= '0;
         start_ff     <= '0;
         step_ff      <= '0;
         run_ff       <= '0;
         pat_ff       <= PAT_OFF;
         phase_ff     <= 1'b0;
         lvl_ff       <= '0;
         on_ff        <= 1'b0;
         duty_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         start_ff     <= start_in;
         step_ff      <= step_in;
         run_ff       <= run_in;
         pat_ff       <= pat_in;
         phase_ff     <= phase_in;
         lvl_ff       <= lvl_in;
         on_ff        <= on_in;
         duty_ff      <= duty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ep_ff        <= ep_in;
      inv_ff       <= inv_in;
      rsp_duty_ff  <= rsp_duty_in;
      rsp_level_ff <= rsp_level_in;
      rsp_lit_ff   <= rsp_lit_in;
      rsp_pat_ff   <= rsp_pat_in;
      rsp_run_ff   <= rsp_run_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_duty            = rsp_duty_ff;
   assign rsp_level           = rsp_level_ff;
   assign rsp_lit             = rsp_lit_ff;
   assign rsp_active_pattern  = rsp_pat_ff;
   assign rsp_pattern_running = rsp_run_ff;

   `LPG_ASSERT_NXT(a_take_leaves_idle, clock, reset, req_take, state_ff != S_IDLE)
   `LPG_ASSERT_IMP(a_div_done_waited, clock, reset, div_rsp.done, state_ff[2] || state_ff[4])
   `LPG_ASSERT_NXT(a_done_posts_item, clock, reset, (state_ff == S_DONE) && out_free, rsp_valid_ff)

endmodule

`default_nettype wire
